// ----- rtl/sts_pkg.sv -----
`default_nettype none

package sts_pkg;

	localparam int DATA_W  = 32;
	localparam int INDEX_W = 10;
	localparam int COUNT_W = 11;

	localparam int REG_ENTRY_COUNT = 0;

	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_SEARCH = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_PROBE  = 4'b0010,
		ST_CMP    = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/sts_mem.sv -----
`default_nettype none

module sts_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic                          clk,
	input  wire sts_pkg::mem_ctl_t             ctl,
	input  wire logic [AW-1:0]                 wr_addr,
	input  wire logic [sts_pkg::DATA_W-1:0]    wr_data,
	input  wire logic [AW-1:0]                 rd_addr,
	output      logic [sts_pkg::DATA_W-1:0]    rd_data
);

	logic [sts_pkg::DATA_W-1:0] mem_q [DEPTH];
	logic [sts_pkg::DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ----- rtl/sts_seq.sv -----
`default_nettype none

module sts_seq #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int CW    = 11
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [sts_pkg::COUNT_W-1:0]         entry_count,
	input  wire logic                                in_valid,
	output      logic                                in_ready,
	input  wire logic                                mode,
	input  wire logic [sts_pkg::INDEX_W-1:0]         index,
	input  wire logic signed [sts_pkg::DATA_W-1:0]   value,
	output      logic                                out_valid,
	input  wire logic                                out_ready,
	output      logic                                found,
	output      sts_pkg::mem_ctl_t                   mem_ctl,
	output      logic [AW-1:0]                       wr_addr,
	output      logic [sts_pkg::DATA_W-1:0]          wr_data,
	output      logic [AW-1:0]                       rd_addr,
	input  wire logic [sts_pkg::DATA_W-1:0]          rd_data
);

	localparam int CMPW = (CW > sts_pkg::COUNT_W) ? CW : sts_pkg::COUNT_W;
	localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);

	sts_pkg::state_t state_q, state_d;

	logic [CW-1:0]                       lo_q, lo_d;
	logic [CW-1:0]                       hi_q, hi_d;
	logic [AW-1:0]                       mid_q, mid_d;
	logic signed [sts_pkg::DATA_W-1:0]   key_q;
	logic                                hit_q, hit_d;
	logic                                out_valid_q;
	logic                                found_q;

	logic                                accept;
	logic                                load_out;
	logic [CMPW-1:0]                     count_ext;
	logic [CW-1:0]                       count_sat;
	logic [CW-1:0]                       span;
	logic [CW-1:0]                       mid_full;
	logic                                range_open;
	logic signed [sts_pkg::DATA_W-1:0]   probe;

	assign in_ready  = (state_q == sts_pkg::ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign load_out  = (state_q == sts_pkg::ST_FINISH) && (!out_valid_q || out_ready);

	assign count_ext = CMPW'(entry_count);
	assign count_sat = (count_ext > DEPTH_C) ? CW'(DEPTH_C) : CW'(count_ext);

	assign range_open = (lo_q < hi_q);
	assign span       = hi_q - lo_q - CW'(1);
	assign mid_full   = lo_q + (span >> 1);
	assign probe      = $signed(rd_data);

	assign mem_ctl.wr_en = accept && (mode == sts_pkg::MODE_WRITE)
		&& (CMPW'(index) < DEPTH_C);
	assign mem_ctl.rd_en = (state_q == sts_pkg::ST_PROBE) && range_open;
	assign wr_addr       = AW'(index);
	assign wr_data       = value;
	assign rd_addr       = mid_d;

	always_comb begin
		state_d = state_q;
		lo_d    = lo_q;
		hi_d    = hi_q;
		mid_d   = mid_q;
		hit_d   = hit_q;
		unique case (state_q)
			sts_pkg::ST_IDLE: begin
				if (accept && (mode == sts_pkg::MODE_SEARCH)) begin
					lo_d    = '0;
					hi_d    = count_sat;
					hit_d   = 1'b0;
					state_d = sts_pkg::ST_PROBE;
				end
			end
			sts_pkg::ST_PROBE: begin
				if (range_open) begin
					mid_d   = AW'(mid_full);
					state_d = sts_pkg::ST_CMP;
				end else begin
					hit_d   = 1'b0;
					state_d = sts_pkg::ST_FINISH;
				end
			end
			sts_pkg::ST_CMP: begin
				if (probe == key_q) begin
					hit_d   = 1'b1;
					state_d = sts_pkg::ST_FINISH;
				end else if (probe < key_q) begin
					lo_d    = CW'(mid_q) + CW'(1);
					state_d = sts_pkg::ST_PROBE;
				end else begin
					hi_d    = CW'(mid_q);
					state_d = sts_pkg::ST_PROBE;
				end
			end
			sts_pkg::ST_FINISH: begin
				if (load_out) begin
					state_d = sts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sts_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sts_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_q  <= lo_d;
		hi_q  <= hi_d;
		mid_q <= mid_d;
		hit_q <= hit_d;
		if (accept) begin
			key_q <= value;
		end
		if (load_out) begin
			found_q <= hit_q;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;

`ifndef SYNTHESIS
	a_cmp_follows_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sts_pkg::ST_CMP) |-> $past(state_q == sts_pkg::ST_PROBE))
		else $error("compare state entered without a preceding read");

	a_range_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sts_pkg::ST_CMP) |-> ((CW'(mid_q) >= lo_q) && (CW'(mid_q) < hi_q)))
		else $error("probe position outside the live range");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == sts_pkg::ST_FINISH))
		else $error("result beat raised outside the finish state");

	a_no_write_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != sts_pkg::ST_IDLE) |-> !mem_ctl.wr_en)
		else $error("table written while a search is running");
`endif

endmodule

`default_nettype wire

// ----- rtl/sorted_table_binary_search_top.sv -----
// Sorted-table binary search.
// Items arrive on the in_valid/in_ready channel. A write beat (mode 0) stores
// value at table position index; it gives no result and the next beat may
// follow in the very next cycle. A search beat (mode 1) looks for value among
// the first entry_count entries, which software must keep in ascending signed
// order, and gives exactly one beat on out_valid/out_ready carrying found.
// A search probes the midpoint of the live range; each probe is a synchronous
// table read followed by a compare. A search stops at the probe that meets
// the key, or when the range empties; the number of probes is at most
// ceil(log2(entry_count + 1)), eleven probes for 1024 entries.
// A search occupies the block: in_ready is low from acceptance until the
// result has been placed in the output register.
// The output register frees the input side: a new item is taken while a result
// still waits. If the receiver stalls, a finished search holds until the
// waiting result is taken.
// entry_count is written over APB at address 0; the user must do so only while
// the block is idle, as the block does not enforce it. Reset clears entry_count
// and control state; no clearing pass runs, so the table is undefined until written.
`default_nettype none

module sorted_table_binary_search_top #(
	parameter int TABLE_DEPTH = 1024
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [2:0]                          paddr,
	input  wire logic [31:0]                         pwdata,
	output      logic [31:0]                         prdata,
	output      logic                                pready,
	input  wire logic                                in_valid,
	output      logic                                in_ready,
	input  wire logic                                mode,
	input  wire logic [sts_pkg::INDEX_W-1:0]         index,
	input  wire logic signed [sts_pkg::DATA_W-1:0]   value,
	output      logic                                out_valid,
	input  wire logic                                out_ready,
	output      logic                                found
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [sts_pkg::COUNT_W-1:0]  entry_count_q;
	logic                         reg_sel;
	sts_pkg::mem_ctl_t            mem_ctl;
	logic [AW-1:0]                wr_addr;
	logic [AW-1:0]                rd_addr;
	logic [sts_pkg::DATA_W-1:0]   wr_data;
	logic [sts_pkg::DATA_W-1:0]   rd_data;

	assign pready  = 1'b1;
	assign reg_sel = (32'(paddr >> 2) == 32'(sts_pkg::REG_ENTRY_COUNT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			entry_count_q <= pwdata[sts_pkg::COUNT_W-1:0];
		end
	end

	assign prdata = reg_sel ? 32'(entry_count_q) : '0;

	sts_seq #(
		.DEPTH(TABLE_DEPTH),
		.AW   (AW),
		.CW   (CW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.entry_count(entry_count_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.index      (index),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.found      (found),
		.mem_ctl    (mem_ctl),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data)
	);

	sts_mem #(
		.DEPTH(TABLE_DEPTH),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.ctl    (mem_ctl),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

endmodule

`default_nettype wire

// ----- bench/sorted_table_binary_search_top_test.sv -----
module sorted_table_binary_search_top_test;

	localparam int DATA_W = sts_pkg::DATA_W;
	localparam int INDEX_W = sts_pkg::INDEX_W;
	localparam int COUNT_W = sts_pkg::COUNT_W;
	localparam int REG_ENTRY_COUNT = sts_pkg::REG_ENTRY_COUNT;
	localparam logic MODE_WRITE = sts_pkg::MODE_WRITE;
	localparam logic MODE_SEARCH = sts_pkg::MODE_SEARCH;

	localparam int DEPTH = 1024;
	localparam int SETTLE = 40;
	localparam int CYCLE_LIMIT = 400000;
	localparam int REG_SPARE = 1;
	localparam logic signed [DATA_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

	typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic               mode;
		logic [INDEX_W-1:0] idx;
		logic [DATA_W-1:0]  val;
		logic               typed;
		logic               want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic mode = MODE_WRITE;
	logic [INDEX_W-1:0] index = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic found;

	logic signed [DATA_W-1:0] table_copy [0:DEPTH-1];
	bit written_copy [0:DEPTH-1];
	int written_list [$];
	logic [COUNT_W-1:0] count_copy = '0;
	bit found_due [$];
	bit due;
	bit calm = 1'b0;
	int error_count = 0;
	int cycle_count = 0;
	int stall_left = 0;
	row_t directed [24];

	sorted_table_binary_search_top #(
		.TABLE_DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.index(index),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sorted_table_binary_search_top_test: done, errors");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		error_count++;
		$display("cycle %0d: %s", cycle_count, what);
	endtask

	function automatic int live_count();
		return (int'(count_copy) > DEPTH) ? DEPTH : int'(count_copy);
	endfunction

	function automatic bit search_table(input logic signed [DATA_W-1:0] key);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = live_count() - 1;
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			if (table_copy[mid] == key)
				return 1'b1;
			if (table_copy[mid] < key)
				lo = mid + 1;
			else
				hi = mid - 1;
		end
		return 1'b0;
	endfunction

	// True when the search for key only probes entries written since reset.
	function automatic bit search_safe(input logic signed [DATA_W-1:0] key);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = live_count() - 1;
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			if (!written_copy[mid])
				return 1'b0;
			if (table_copy[mid] == key)
				return 1'b1;
			if (table_copy[mid] < key)
				lo = mid + 1;
			else
				hi = mid - 1;
		end
		return 1'b1;
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (found_due.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				due = found_due.pop_front();
				if (found !== due)
					report_mismatch($sformatf("found %b, expected %b", found, due));
			end
		end
	end

	// A receiver stall only begins after at least one ready cycle.
	always @(negedge clk) begin
		if (!calm && out_ready && stall_left == 0 && $urandom_range(0, 3) == 0)
			stall_left = $urandom_range(1, 5);
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_beat(input logic m, input logic [INDEX_W-1:0] i,
			input logic [DATA_W-1:0] v, input bit typed, input bit want);
		@(negedge clk);
		in_valid <= 1'b1;
		mode <= m;
		index <= i;
		value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (m == MODE_WRITE) begin
			table_copy[i] = v;
			written_copy[i] = 1'b1;
			written_list.push_back(int'(i));
		end else begin
			found_due.push_back(typed ? want : search_table(v));
		end
	endtask

	task automatic maybe_idle();
		if (!calm && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 4))
				@(negedge clk);
		end
	endtask

	task automatic quiesce();
		@(negedge clk);
		in_valid <= 1'b0;
		while (found_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE)
			@(posedge clk);
	endtask

	task automatic cfg_write(input int reg_index, input logic [31:0] data);
		logic [31:0] rd;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(4 * reg_index);
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_index == REG_ENTRY_COUNT)
			count_copy = data[COUNT_W-1:0];
		@(negedge clk);
		psel <= 1'b1;
		paddr <= 3'(4 * REG_ENTRY_COUNT);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd !== 32'(count_copy))
			report_mismatch($sformatf("entry_count reads %0d, expected %0d", rd, count_copy));
	endtask

	task automatic fill_sorted(input int n, input int span, input bit low_start);
		longint v;
		v = low_start ? longint'(KEY_MIN) : longint'($signed($urandom));
		for (int i = 0; i < n; i++) begin
			maybe_idle();
			send_beat(MODE_WRITE, INDEX_W'(i), DATA_W'(v), 1'b0, 1'b0);
			v += $urandom_range(0, span);
			if (v > longint'(KEY_MAX))
				v = longint'(KEY_MAX);
		end
	endtask

	// Writes base + 4*i at every position that a search over n entries visits on
	// its way towards the odd half-position t2 / 2.
	task automatic write_path(input int n, input int t2, input longint base);
		int lo;
		int hi;
		int mid;
		logic [DATA_W-1:0] f;
		lo = 0;
		hi = n - 1;
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			f = DATA_W'(base + longint'(4 * mid));
			if (!written_copy[mid] || table_copy[mid] !== f) begin
				maybe_idle();
				send_beat(MODE_WRITE, INDEX_W'(mid), f, 1'b0, 1'b0);
			end
			if (2 * mid < t2)
				lo = mid + 1;
			else
				hi = mid - 1;
		end
	endtask

	function automatic logic [DATA_W-1:0] pick_key();
		logic [DATA_W-1:0] k;
		int r;
		int pos;
		r = $urandom_range(0, 7);
		k = $urandom;
		if (r < 6 && written_list.size() > 0) begin
			pos = written_list[$urandom_range(0, written_list.size() - 1)];
			k = table_copy[pos];
			if (r == 4)
				k = k + DATA_W'(1);
			else if (r == 5)
				k = k - DATA_W'(1);
		end else if (r == 7) begin
			k = $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
		end
		return k;
	endfunction

	// Mostly searches; a few writes land past the live range, and a rare one
	// anywhere or at the middle entry, which may leave the live range out of order.
	task automatic run_lookups(input int beats);
		int n;
		int r;
		int tries;
		logic [DATA_W-1:0] k;
		n = live_count();
		repeat (beats) begin
			r = $urandom_range(0, 19);
			maybe_idle();
			if (r == 0) begin
				send_beat(MODE_WRITE, INDEX_W'($urandom), $urandom, 1'b0, 1'b0);
			end else if (r < 3 && n < DEPTH) begin
				send_beat(MODE_WRITE, INDEX_W'($urandom_range(n, DEPTH - 1)), $urandom,
					1'b0, 1'b0);
			end else begin
				k = pick_key();
				tries = 0;
				while (!search_safe(k) && tries < 16) begin
					k = pick_key();
					tries++;
				end
				if (!search_safe(k) && written_copy[(n - 1) / 2])
					k = table_copy[(n - 1) / 2];
				if (search_safe(k))
					send_beat(MODE_SEARCH, INDEX_W'($urandom), k, 1'b0, 1'b0);
				else
					send_beat(MODE_WRITE, INDEX_W'((n - 1) / 2), $urandom, 1'b0, 1'b0);
			end
		end
	endtask

	initial begin
		row_t row;
		int count;
		int span;
		int sel;
		int t;
		longint base;
		bit low_start;
		directed = '{
			'{ROW_BEAT, MODE_SEARCH, 10'd0,   32'h0000_0000, 1'b1, 1'b0},
			'{ROW_BEAT, MODE_SEARCH, 10'h3FF, 32'h7FFF_FFFF, 1'b1, 1'b0},
			'{ROW_BEAT, MODE_WRITE,  10'd0,   32'h8000_0000, 1'b0, 1'b0},
			'{ROW_BEAT, MODE_WRITE,  10'd1,   32'hFFFF_FFFB, 1'b0, 1'b0},
			'{ROW_BEAT, MODE_WRITE,  10'd2,   32'h0000_0000, 1'b0, 1'b0},
			'{ROW_BEAT, MODE_WRITE,  10'd3,   32'h0000_0007, 1'b0, 1'b0},
			'{ROW_BEAT, MODE_WRITE,  10'd4,   32'h7FFF_FFFF, 1'b0, 1'b0},
			'{ROW_BEAT, MODE_WRITE,  10'h3FF, 32'h7FFF_FFFF, 1'b0, 1'b0},
			'{ROW_CFG,  MODE_WRITE,  10'(REG_ENTRY_COUNT), 32'd5, 1'b0, 1'b0},
			'{ROW_BEAT, MODE_SEARCH, 10'd0,   32'h8000_0000, 1'b1, 1'b1},
			'{ROW_BEAT, MODE_SEARCH, 10'd0,   32'h7FFF_FFFF, 1'b1, 1'b1},
			'{ROW_BEAT, MODE_SEARCH, 10'd0,   32'h0000_0000, 1'b0, 1'b0},
			'{ROW_BEAT, MODE_SEARCH, 10'd0,   32'h0000_0001, 1'b0, 1'b0},
			'{ROW_BEAT, MODE_SEARCH, 10'd0,   32'hFFFF_FFFC, 1'b0, 1'b0},
			'{ROW_BEAT, MODE_SEARCH, 10'd0,   32'h8000_0001, 1'b0, 1'b0},
			'{ROW_BEAT, MODE_SEARCH, 10'h3FF, 32'h0000_0007, 1'b0, 1'b0},
			'{ROW_CFG,  MODE_WRITE,  10'(REG_SPARE), 32'hFFFF_FFFF, 1'b0, 1'b0},
			'{ROW_BEAT, MODE_SEARCH, 10'd0,   32'hFFFF_FFFB, 1'b0, 1'b0},
			'{ROW_CFG,  MODE_WRITE,  10'(REG_ENTRY_COUNT), 32'd1, 1'b0, 1'b0},
			'{ROW_BEAT, MODE_SEARCH, 10'd0,   32'h8000_0000, 1'b1, 1'b1},
			'{ROW_BEAT, MODE_SEARCH, 10'd0,   32'h0000_0000, 1'b0, 1'b0},
			'{ROW_CFG,  MODE_WRITE,  10'(REG_ENTRY_COUNT), 32'd0, 1'b0, 1'b0},
			'{ROW_BEAT, MODE_SEARCH, 10'd0,   32'h8000_0000, 1'b1, 1'b0},
			'{ROW_BEAT, MODE_SEARCH, 10'd0,   32'h0000_0000, 1'b1, 1'b0}
		};
		repeat (8)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[r]) begin
			row = directed[r];
			if (row.kind == ROW_CFG) begin
				quiesce();
				cfg_write(int'(row.idx), row.val);
			end else begin
				maybe_idle();
				send_beat(row.mode, row.idx, row.val, row.typed, row.want);
			end
		end

		// Only the search paths towards a few positions of the full table are written.
		base = longint'($signed($urandom)) / 2;
		for (int j = 0; j < 4; j++) begin
			if (j == 0)
				t = 0;
			else if (j == 1)
				t = DEPTH - 1;
			else
				t = $urandom_range(0, DEPTH - 1);
			write_path(DEPTH, 2 * t + 1, base);
			write_path(DEPTH, 2 * t - 1, base);
		end
		quiesce();
		cfg_write(REG_ENTRY_COUNT, 32'(DEPTH));
		run_lookups(20);
		quiesce();
		cfg_write(REG_ENTRY_COUNT, ($urandom & ~32'h7FF) | 32'($urandom_range(DEPTH + 1, 2047)));
		run_lookups(20);

		for (int p = 0; p < 10; p++) begin
			if (p == 7)
				calm = 1'b1;
			if ($urandom_range(0, 5) == 0) begin
				count = $urandom_range(0, 2047);
			end else begin
				sel = $urandom_range(0, 7);
				case (sel)
					0: count = 0;
					1: count = 1;
					2: count = 2;
					3: count = $urandom_range(41, 120);
					default: count = $urandom_range(3, 40);
				endcase
				case ($urandom_range(0, 3))
					0: span = 0;
					1: span = 3;
					2: span = 1000;
					default: span = 32'h0FFF_FFFF;
				endcase
				low_start = ($urandom_range(0, 3) == 0);
				fill_sorted(count, span, low_start);
			end
			quiesce();
			cfg_write(REG_ENTRY_COUNT, ($urandom & ~32'h7FF) | 32'(count));
			run_lookups(16);
		end

		quiesce();
		if (error_count == 0)
			$display("sorted_table_binary_search_top_test: done, clean");
		else
			$display("sorted_table_binary_search_top_test: done, errors");
		$finish;
	end

endmodule

// ----- sorted_table_binary_search_top.f -----
rtl/sts_pkg.sv
rtl/sts_mem.sv
rtl/sts_seq.sv
rtl/sorted_table_binary_search_top.sv
bench/sorted_table_binary_search_top_test.sv
